/* sv/pdsf_pkg.sv */
// Shared constants, codes and types for the pipelined decode stage.
package pdsf_pkg;

   // Parameter defaults
   localparam int DATA_WIDTH_DEF = 32;
   localparam int REG_COUNT_DEF  = 8;

   // Request word layout (req_tdata), lowest bit first
   localparam int REQ_TDATA_W     = 272;
   localparam int REQ_TUSER_W     = 2;
   localparam int IN_WORD_LSB     = 0;
   localparam int IN_REGS_LSB     = 10;
   localparam int IN_CONST_LSB    = 18;
   localparam int IN_NPC_LSB      = 50;
   localparam int IN_EXEC_LSB     = 82;
   localparam int IN_DESTS_LSB    = 91;
   localparam int IN_VAL_LSB      = 111;
   localparam int VAL_W           = 32;
   localparam int FWD_COUNT       = 5;

   // Response word layout (rsp_tdata)
   localparam int RSP_TDATA_W     = 128;
   localparam int RSP_TUSER_W     = 2;
   localparam int RSP_PAD_W       = 6;

   // Actions carried in req_tuser
   localparam logic [1:0] ACT_STEP    = 2'd0;
   localparam logic [1:0] ACT_RESTART = 2'd1;
   localparam logic [1:0] ACT_END     = 2'd2;

   // Instruction codes
   localparam logic [3:0] CODE_NOP   = 4'd1;
   localparam logic [3:0] CODE_RRMOV = 4'd2;
   localparam logic [3:0] CODE_IRMOV = 4'd3;
   localparam logic [3:0] CODE_RMMOV = 4'd4;
   localparam logic [3:0] CODE_MRMOV = 4'd5;
   localparam logic [3:0] CODE_OPQ   = 4'd6;
   localparam logic [3:0] CODE_JXX   = 4'd7;
   localparam logic [3:0] CODE_CALL  = 4'd8;
   localparam logic [3:0] CODE_RET   = 4'd9;
   localparam logic [3:0] CODE_PUSH  = 4'd10;
   localparam logic [3:0] CODE_POP   = 4'd11;

   // Register indexes
   localparam logic [3:0] REG_NONE = 4'd15;
   localparam logic [3:0] REG_SP   = 4'd4;

   // Status code for a good fetch
   localparam logic [1:0] STAT_OK = 2'd0;

   // Which register bank holds the latest value of an entry
   typedef enum logic [1:0] {
      LVT_ZERO,
      LVT_BANK_E,
      LVT_BANK_M
   } lvt_code_type;

   // Register file write request from the writeback fields
   typedef struct packed {
      logic       en;
      logic [3:0] idx_e;
      logic [3:0] idx_m;
   } rf_write_type;

endpackage

/* sv/pdsf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pdsf_ram #(
   parameter int WIDTH = pdsf_pkg::DATA_WIDTH_DEF,
   parameter int DEPTH = pdsf_pkg::REG_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read at the write edge returns the old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pdsf_regfile.sv */
// Register file: two write banks with a live-value table, two read ports.
module pdsf_regfile #(
   parameter int DATA_WIDTH = pdsf_pkg::DATA_WIDTH_DEF,
   parameter int REG_COUNT  = pdsf_pkg::REG_COUNT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pdsf_pkg::rf_write_type     wr,
   input  logic [DATA_WIDTH-1:0]      wr_data_e,
   input  logic [DATA_WIDTH-1:0]      wr_data_m,
   input  logic                       rd_en,
   input  logic [3:0]                 rd_idx_a,
   input  logic [3:0]                 rd_idx_b,
   output logic [DATA_WIDTH-1:0]      rd_data_a,
   output logic [DATA_WIDTH-1:0]      rd_data_b
);

   localparam int AW = $clog2(REG_COUNT);

   pdsf_pkg::lvt_code_type lvt_ff [REG_COUNT];
   pdsf_pkg::lvt_code_type lvt_a_ff, lvt_a_in;
   pdsf_pkg::lvt_code_type lvt_b_ff, lvt_b_in;
   logic                   we_e, we_m;
   logic                   in_range_a, in_range_b;
   logic [DATA_WIDTH-1:0]  ea_q, eb_q, ma_q, mb_q;

   // Indexes past the file are ignored on write and read as zero
   assign we_e       = wr.en && (wr.idx_e < 4'(REG_COUNT));
   assign we_m       = wr.en && (wr.idx_m < 4'(REG_COUNT));
   assign in_range_a = rd_idx_a < 4'(REG_COUNT);
   assign in_range_b = rd_idx_b < 4'(REG_COUNT);

   // Live-value table; the M write wins when both hit one entry
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            lvt_ff[i] <= pdsf_pkg::LVT_ZERO;
         end
      end else begin
         if (we_e) begin
            lvt_ff[wr.idx_e[AW-1:0]] <= pdsf_pkg::LVT_BANK_E;
         end
         if (we_m) begin
            lvt_ff[wr.idx_m[AW-1:0]] <= pdsf_pkg::LVT_BANK_M;
         end
      end
   end

   // Bank select sampled with the RAM read, old contents as seen at the edge
   assign lvt_a_in = in_range_a ? lvt_ff[rd_idx_a[AW-1:0]] : pdsf_pkg::LVT_ZERO;
   assign lvt_b_in = in_range_b ? lvt_ff[rd_idx_b[AW-1:0]] : pdsf_pkg::LVT_ZERO;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         lvt_a_ff <= lvt_a_in;
         lvt_b_ff <= lvt_b_in;
      end
   end

   // One RAM per bank and read port
   pdsf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_ram_ea (
      .clock   (clock),
      .wr_en   (we_e),
      .wr_addr (wr.idx_e[AW-1:0]),
      .wr_data (wr_data_e),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_a[AW-1:0]),
      .rd_data (ea_q)
   );

   pdsf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_ram_eb (
      .clock   (clock),
      .wr_en   (we_e),
      .wr_addr (wr.idx_e[AW-1:0]),
      .wr_data (wr_data_e),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_b[AW-1:0]),
      .rd_data (eb_q)
   );

   pdsf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_ram_ma (
      .clock   (clock),
      .wr_en   (we_m),
      .wr_addr (wr.idx_m[AW-1:0]),
      .wr_data (wr_data_m),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_a[AW-1:0]),
      .rd_data (ma_q)
   );

   pdsf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_ram_mb (
      .clock   (clock),
      .wr_en   (we_m),
      .wr_addr (wr.idx_m[AW-1:0]),
      .wr_data (wr_data_m),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_b[AW-1:0]),
      .rd_data (mb_q)
   );

   // Pick the live bank
   always_comb begin
      unique case (lvt_a_ff)
         pdsf_pkg::LVT_BANK_E: rd_data_a = ea_q;
         pdsf_pkg::LVT_BANK_M: rd_data_a = ma_q;
         default:              rd_data_a = '0;
      endcase
      unique case (lvt_b_ff)
         pdsf_pkg::LVT_BANK_E: rd_data_b = eb_q;
         pdsf_pkg::LVT_BANK_M: rd_data_b = mb_q;
         default:              rd_data_b = '0;
      endcase
   end

endmodule

/* sv/pipelined_decode_stage_forwarding.sv */
// Top level of the pipelined decode stage with operand forwarding.
// Decode stage of a five-stage pipeline: one request word is one clock step,
// restart or end action, and each request word yields exactly one response
// word. A new word is taken every cycle unless the output register stalls
// stage 1; a word passes the stage 1 register, beside the register file
// read (registered RAM read), then the operand select into the output
// register. Decoding, hazard detection and the replay state update happen
// at the accept edge, so back-to-back steps see each other's register file
// writes and replays without gaps. The register file holds REG_COUNT entries
// of DATA_WIDTH bits, read-as-zero after reset with no clearing pass.
module pipelined_decode_stage_forwarding #(
   parameter int DATA_WIDTH = pdsf_pkg::DATA_WIDTH_DEF,
   parameter int REG_COUNT  = pdsf_pkg::REG_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // fetch_word, fetch_regs, fetch_const, fetch_next_pc, exec_info, fwd_dests,
   // exec_result, mem_loaded, mem_alu_value, wb_loaded, wb_alu_value
   input  logic [pdsf_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action
   input  logic [pdsf_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // out_stat, out_code, out_sources, out_dests, out_val_a, out_val_b, out_val_c
   output logic [pdsf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // out_valid, out_load_bubble
   output logic [pdsf_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);

   typedef struct packed {
      logic        out_valid;
      logic [1:0]  stat;
      logic [7:0]  code;
      logic [7:0]  sources;
      logic [7:0]  dests;
      logic [31:0] pre_a;
      logic [31:0] pre_b;
      logic [31:0] val_c;
      logic        load_bubble;
      logic        rf_a;
      logic        rf_b;
   } stage_type;

   // Request fields
   logic [1:0]  action;
   logic [1:0]  stat;
   logic [3:0]  fcode, ifun, ra, rb, ecode, edstm;
   logic        cnd;
   logic [31:0] cval, npc;
   logic [3:0]  dst [pdsf_pkg::FWD_COUNT];
   logic signed [31:0]     val_s  [pdsf_pkg::FWD_COUNT];
   logic [DATA_WIDTH-1:0]  fwd_dw [pdsf_pkg::FWD_COUNT];
   logic [31:0]            fwd_out[pdsf_pkg::FWD_COUNT];

   // State
   logic       replay_ff, replay_in;
   logic [3:0] held_ff, held_in;
   logic       ended_ff, ended_in;

   // Decode
   logic       step, accept, mispredict, hazard, load_op;
   logic [3:0] code_sel, code_fin;
   logic [3:0] sa0, sb0, de0, dm0, sa, sb, de, dm;
   logic       use_c;
   logic       hit_a, hit_b;
   logic [31:0] fv_a, fv_b;
   stage_type  s1_in, s1_ff;
   logic       s1_vld_ff, s1_vld_in, s1_adv;

   // Register file
   pdsf_pkg::rf_write_type rf_wr;
   logic [DATA_WIDTH-1:0]  rf_a_q, rf_b_q;

   // Output register
   logic [pdsf_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [pdsf_pkg::RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;
   logic                             rsp_vld_ff, rsp_vld_in;
   logic [31:0]                      out_a, out_b;

   // Unpack the request word
   assign action = req_tuser;
   assign stat   = req_tdata[pdsf_pkg::IN_WORD_LSB + 8 +: 2];
   assign fcode  = req_tdata[pdsf_pkg::IN_WORD_LSB + 4 +: 4];
   assign ifun   = req_tdata[pdsf_pkg::IN_WORD_LSB +: 4];
   assign ra     = req_tdata[pdsf_pkg::IN_REGS_LSB + 4 +: 4];
   assign rb     = req_tdata[pdsf_pkg::IN_REGS_LSB +: 4];
   assign cval   = req_tdata[pdsf_pkg::IN_CONST_LSB +: 32];
   assign npc    = req_tdata[pdsf_pkg::IN_NPC_LSB +: 32];
   assign ecode  = req_tdata[pdsf_pkg::IN_EXEC_LSB + 5 +: 4];
   assign cnd    = req_tdata[pdsf_pkg::IN_EXEC_LSB + 4];
   assign edstm  = req_tdata[pdsf_pkg::IN_EXEC_LSB +: 4];

   // Forwarding destinations and values, widened to the file width
   always_comb begin
      for (int i = 0; i < pdsf_pkg::FWD_COUNT; i++) begin
         dst[i]     = req_tdata[pdsf_pkg::IN_DESTS_LSB + 16 - 4 * i +: 4];
         val_s[i]   = signed'(req_tdata[pdsf_pkg::IN_VAL_LSB
                                        + pdsf_pkg::VAL_W * i +: pdsf_pkg::VAL_W]);
         fwd_dw[i]  = DATA_WIDTH'(val_s[i]);
         fwd_out[i] = 32'(fwd_dw[i]);
      end
   end

   // Handshake: stage 1 moves when the output register is free
   assign s1_adv     = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign step       = (action == pdsf_pkg::ACT_STEP) && !ended_ff;

   // Code selection: mispredict bubble, then replay, then fetch
   assign mispredict = (ecode == pdsf_pkg::CODE_JXX) && !cnd;
   assign load_op    = (ecode == pdsf_pkg::CODE_MRMOV) || (ecode == pdsf_pkg::CODE_POP);

   always_comb begin
      priority if (mispredict) begin
         code_sel = pdsf_pkg::CODE_NOP;
      end else if (replay_ff) begin
         code_sel = held_ff;
      end else begin
         code_sel = fcode;
      end
   end

   // Sources, destinations and constant by code
   always_comb begin
      sa0   = pdsf_pkg::REG_NONE;
      sb0   = pdsf_pkg::REG_NONE;
      de0   = pdsf_pkg::REG_NONE;
      dm0   = pdsf_pkg::REG_NONE;
      use_c = 1'b0;
      unique case (code_sel)
         pdsf_pkg::CODE_RRMOV: begin
            sa0 = ra;
            de0 = rb;
         end
         pdsf_pkg::CODE_IRMOV: begin
            de0   = rb;
            use_c = 1'b1;
         end
         pdsf_pkg::CODE_RMMOV: begin
            sa0   = ra;
            sb0   = rb;
            use_c = 1'b1;
         end
         pdsf_pkg::CODE_MRMOV: begin
            sb0   = rb;
            dm0   = ra;
            use_c = 1'b1;
         end
         pdsf_pkg::CODE_OPQ: begin
            sa0 = ra;
            sb0 = rb;
            de0 = rb;
         end
         pdsf_pkg::CODE_CALL: begin
            sb0 = pdsf_pkg::REG_SP;
            de0 = pdsf_pkg::REG_SP;
         end
         pdsf_pkg::CODE_RET: begin
            sa0 = pdsf_pkg::REG_SP;
            sb0 = pdsf_pkg::REG_SP;
            de0 = pdsf_pkg::REG_SP;
         end
         pdsf_pkg::CODE_PUSH: begin
            sa0 = ra;
            sb0 = pdsf_pkg::REG_SP;
            de0 = pdsf_pkg::REG_SP;
         end
         pdsf_pkg::CODE_POP: begin
            sa0 = pdsf_pkg::REG_SP;
            sb0 = pdsf_pkg::REG_SP;
            de0 = pdsf_pkg::REG_SP;
            dm0 = ra;
         end
         default: begin
         end
      endcase
   end

   // Load-use hazard turns the word into a bubble
   assign hazard = (stat == pdsf_pkg::STAT_OK) && load_op
                   && (((sa0 != pdsf_pkg::REG_NONE) && (edstm == sa0))
                       || ((sb0 != pdsf_pkg::REG_NONE) && (edstm == sb0)));
   assign code_fin = hazard ? pdsf_pkg::CODE_NOP : code_sel;
   assign sa       = hazard ? pdsf_pkg::REG_NONE : sa0;
   assign sb       = hazard ? pdsf_pkg::REG_NONE : sb0;
   assign de       = hazard ? pdsf_pkg::REG_NONE : de0;
   assign dm       = hazard ? pdsf_pkg::REG_NONE : dm0;

   // Forwarding search: execute first, writeback ALU last
   always_comb begin
      hit_a = 1'b0;
      hit_b = 1'b0;
      fv_a  = '0;
      fv_b  = '0;
      for (int i = pdsf_pkg::FWD_COUNT - 1; i >= 0; i--) begin
         if ((sa != pdsf_pkg::REG_NONE) && (dst[i] == sa)) begin
            hit_a = 1'b1;
            fv_a  = fwd_out[i];
         end
         if ((sb != pdsf_pkg::REG_NONE) && (dst[i] == sb)) begin
            hit_b = 1'b1;
            fv_b  = fwd_out[i];
         end
      end
   end

   // Stage 1 contents; a non-step word leaves zeros, a nonzero stat keeps only valid and stat
   always_comb begin
      s1_in = '0;
      if (step) begin
         s1_in.out_valid = 1'b1;
         s1_in.stat      = stat;
         if (stat == pdsf_pkg::STAT_OK) begin
            s1_in.code        = {code_fin, ifun};
            s1_in.sources     = {sa, sb};
            s1_in.dests       = {de, dm};
            s1_in.val_c       = (use_c && !hazard) ? cval : '0;
            s1_in.load_bubble = hazard;
            if ((code_fin == pdsf_pkg::CODE_JXX) || (code_fin == pdsf_pkg::CODE_CALL)) begin
               s1_in.pre_a = npc;
            end else begin
               s1_in.pre_a = fv_a;
               s1_in.rf_a  = !hit_a && (sa < 4'(REG_COUNT));
            end
            s1_in.pre_b = fv_b;
            s1_in.rf_b  = !hit_b && (sb < 4'(REG_COUNT));
         end
      end
   end

   // Replay and end-of-program state
   always_comb begin
      replay_in = replay_ff;
      held_in   = held_ff;
      ended_in  = ended_ff;
      if (accept) begin
         unique case (action)
            pdsf_pkg::ACT_RESTART: begin
               replay_in = 1'b0;
               ended_in  = 1'b0;
            end
            pdsf_pkg::ACT_END: begin
               ended_in = 1'b1;
            end
            pdsf_pkg::ACT_STEP: begin
               if (!ended_ff) begin
                  if (!mispredict) begin
                     replay_in = 1'b0;
                  end
                  if (hazard) begin
                     replay_in = 1'b1;
                     held_in   = code_sel;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Register file, written from the writeback fields of each step
   assign rf_wr.en    = accept && step;
   assign rf_wr.idx_e = dst[4];
   assign rf_wr.idx_m = dst[3];

   pdsf_regfile #(.DATA_WIDTH(DATA_WIDTH), .REG_COUNT(REG_COUNT)) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr        (rf_wr),
      .wr_data_e (fwd_dw[4]),
      .wr_data_m (fwd_dw[3]),
      .rd_en     (accept),
      .rd_idx_a  (sa),
      .rd_idx_b  (sb),
      .rd_data_a (rf_a_q),
      .rd_data_b (rf_b_q)
   );

   // Operand select and response word
   assign out_a = s1_ff.rf_a ? 32'(rf_a_q) : s1_ff.pre_a;
   assign out_b = s1_ff.rf_b ? 32'(rf_b_q) : s1_ff.pre_b;

   assign rsp_tdata_in = {{pdsf_pkg::RSP_PAD_W{1'b0}}, s1_ff.val_c, out_b, out_a,
                          s1_ff.dests, s1_ff.sources, s1_ff.code, s1_ff.stat};
   assign rsp_tuser_in = {s1_ff.load_bubble, s1_ff.out_valid};

   // Valid flags
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      rsp_vld_in = s1_adv ? s1_vld_ff : rsp_vld_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         replay_ff  <= 1'b0;
         held_ff    <= '0;
         ended_ff   <= 1'b0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         replay_ff  <= replay_in;
         held_ff    <= held_in;
         ended_ff   <= ended_in;
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv && s1_vld_ff) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tvalid = rsp_vld_ff;

   // After end, accepted words decode to an empty result
   a_ended_empty: assert property (@(posedge clock) disable iff (reset)
      accept && ended_ff |=> s1_vld_ff && !s1_ff.out_valid)
      else $error("word decoded after end of program");

   // A load-use bubble leaves a replay pending
   a_hazard_replay: assert property (@(posedge clock) disable iff (reset)
      accept && step && hazard |=> replay_ff)
      else $error("load-use bubble without pending replay");

   // A load-use bubble carries the bubble code and no registers
   a_bubble_shape: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s1_ff.load_bubble |->
         (s1_ff.code[7:4] == pdsf_pkg::CODE_NOP)
         && (s1_ff.sources == {pdsf_pkg::REG_NONE, pdsf_pkg::REG_NONE})
         && (s1_ff.dests == {pdsf_pkg::REG_NONE, pdsf_pkg::REG_NONE}))
      else $error("malformed load-use bubble");

   // A stalled stage 1 word is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_adv |=> s1_vld_ff && $stable(s1_ff))
      else $error("stage 1 word lost under stall");

endmodule

/* tb/sv/tb_pipelined_decode_stage_forwarding.sv */
// Self-checking testbench for the pipelined decode stage with operand forwarding.
module tb_pipelined_decode_stage_forwarding;

   // Codes without a name in the package
   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam logic [3:0] CODE_HALT   = 4'd0;
   localparam logic [3:0] CODE_NONE   = 4'd15;

   localparam int RF_DEPTH     = pdsf_pkg::REG_COUNT_DEF;
   localparam int RF_AW        = $clog2(RF_DEPTH);
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 8;
   localparam int LIMIT_CYCLES = 400000;

   // One fetched instruction plus the later stages' forwarding view
   typedef struct packed {
      logic [1:0]       action;
      logic [1:0]       stat;
      logic [3:0]       code;
      logic [3:0]       ifun;
      logic [3:0]       reg_a;
      logic [3:0]       reg_b;
      logic [31:0]      const_word;
      logic [31:0]      next_pc;
      logic [3:0]       ex_code;
      logic             ex_cond;
      logic [3:0]       ex_load_dst;
      logic [4:0][3:0]  fwd_dst;   // exec E, mem M, mem E, wb M, wb E
      logic [4:0][31:0] fwd_val;
   } fetch_item_type;

   // One decoded word as it leaves the stage
   typedef struct packed {
      logic        valid;
      logic [1:0]  stat;
      logic [7:0]  code;
      logic [7:0]  sources;
      logic [7:0]  dests;
      logic [31:0] val_a;
      logic [31:0] val_b;
      logic [31:0] val_c;
      logic        load_bubble;
   } decoded_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic [pdsf_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [pdsf_pkg::REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [pdsf_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [pdsf_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;

   // Shadow state of the decode stage
   logic        replay_pending = 1'b0;
   logic [3:0]  held_op        = '0;
   logic        program_ended  = 1'b0;
   logic [31:0] rf_shadow [RF_DEPTH];

   decoded_type expected_decodes [$];
   int mismatches      = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int load_bubbles    = 0;
   int stat_faults     = 0;
   int burst_left      = 0;
   int cycle_count     = 0;
   int hold_asks       = 0;
   int hold_seen       = 0;
   int hold_left       = 0;
   int pattern_mode    = 0;
   int pattern_left    = 0;

   pipelined_decode_stage_forwarding DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #6 clock = ~clock;

   initial begin
      for (int i = 0; i < RF_DEPTH; i++) rf_shadow[i] = '0;
   end

   // Operand lookup: forwarding sources in priority order, then the file
   function automatic logic [31:0] read_operand(logic [3:0] src, fetch_item_type f);
      if (src == pdsf_pkg::REG_NONE) return '0;
      for (int i = 0; i < pdsf_pkg::FWD_COUNT; i++)
         if (f.fwd_dst[i] == src) return f.fwd_val[i];
      if (src < RF_DEPTH) return rf_shadow[src[RF_AW-1:0]];
      return '0;
   endfunction

   // Decode one accepted word and advance the shadow state
   function automatic decoded_type predict_decode(fetch_item_type f);
      decoded_type r;
      logic [3:0]  op, sa, sb, de, dm;
      logic [31:0] vc;
      logic        ld_bubble;
      r = '0;
      if (f.action == pdsf_pkg::ACT_RESTART) begin
         replay_pending = 1'b0;
         program_ended  = 1'b0;
         return r;
      end
      if (f.action == pdsf_pkg::ACT_END) begin
         program_ended = 1'b1;
         return r;
      end
      if (f.action != pdsf_pkg::ACT_STEP || program_ended) return r;

      sa = pdsf_pkg::REG_NONE;
      sb = pdsf_pkg::REG_NONE;
      de = pdsf_pkg::REG_NONE;
      dm = pdsf_pkg::REG_NONE;
      vc = '0;
      ld_bubble = 1'b0;

      // mispredict beats replay; replay beats the fetched code
      if (f.ex_code == pdsf_pkg::CODE_JXX && !f.ex_cond) begin
         op = pdsf_pkg::CODE_NOP;
      end else if (replay_pending) begin
         op = held_op;
         replay_pending = 1'b0;
      end else begin
         op = f.code;
      end

      if (f.stat == pdsf_pkg::STAT_OK) begin
         case (op)
            pdsf_pkg::CODE_RRMOV: begin sa = f.reg_a; de = f.reg_b; end
            pdsf_pkg::CODE_IRMOV: begin de = f.reg_b; vc = f.const_word; end
            pdsf_pkg::CODE_RMMOV: begin
               sa = f.reg_a; sb = f.reg_b; vc = f.const_word;
            end
            pdsf_pkg::CODE_MRMOV: begin
               sb = f.reg_b; dm = f.reg_a; vc = f.const_word;
            end
            pdsf_pkg::CODE_OPQ: begin sa = f.reg_a; sb = f.reg_b; de = f.reg_b; end
            pdsf_pkg::CODE_CALL: begin
               sb = pdsf_pkg::REG_SP; de = pdsf_pkg::REG_SP;
            end
            pdsf_pkg::CODE_RET: begin
               sa = pdsf_pkg::REG_SP; sb = pdsf_pkg::REG_SP; de = pdsf_pkg::REG_SP;
            end
            pdsf_pkg::CODE_PUSH: begin
               sa = f.reg_a; sb = pdsf_pkg::REG_SP; de = pdsf_pkg::REG_SP;
            end
            pdsf_pkg::CODE_POP: begin
               sa = pdsf_pkg::REG_SP; sb = pdsf_pkg::REG_SP; de = pdsf_pkg::REG_SP;
               dm = f.reg_a;
            end
            default: ;
         endcase
         // load in execute feeding one of our sources
         if ((f.ex_code == pdsf_pkg::CODE_MRMOV || f.ex_code == pdsf_pkg::CODE_POP) &&
             ((sa != pdsf_pkg::REG_NONE && f.ex_load_dst == sa) ||
              (sb != pdsf_pkg::REG_NONE && f.ex_load_dst == sb))) begin
            held_op = op;
            replay_pending = 1'b1;
            ld_bubble = 1'b1;
            op = pdsf_pkg::CODE_NOP;
            sa = pdsf_pkg::REG_NONE;
            sb = pdsf_pkg::REG_NONE;
            de = pdsf_pkg::REG_NONE;
            dm = pdsf_pkg::REG_NONE;
            vc = '0;
         end
         r.code        = {op, f.ifun};
         r.sources     = {sa, sb};
         r.dests       = {de, dm};
         r.val_a       = (op == pdsf_pkg::CODE_JXX || op == pdsf_pkg::CODE_CALL)
                         ? f.next_pc : read_operand(sa, f);
         r.val_b       = read_operand(sb, f);
         r.val_c       = vc;
         r.load_bubble = ld_bubble;
      end
      r.valid = 1'b1;
      r.stat  = f.stat;

      // writeback: M port lands last, so it wins on equal indexes
      if (f.fwd_dst[4] < RF_DEPTH) rf_shadow[f.fwd_dst[4][RF_AW-1:0]] = f.fwd_val[4];
      if (f.fwd_dst[3] < RF_DEPTH) rf_shadow[f.fwd_dst[3][RF_AW-1:0]] = f.fwd_val[3];
      return r;
   endfunction

   // Plain clock step with nothing forwarded and nothing in execute
   function automatic fetch_item_type base_step(logic [3:0] code, logic [3:0] ifun,
                                                logic [3:0] ra, logic [3:0] rb);
      fetch_item_type f;
      f.action      = pdsf_pkg::ACT_STEP;
      f.stat        = pdsf_pkg::STAT_OK;
      f.code        = code;
      f.ifun        = ifun;
      f.reg_a       = ra;
      f.reg_b       = rb;
      f.const_word  = $urandom;
      f.next_pc     = $urandom;
      f.ex_code     = CODE_NONE;
      f.ex_cond     = 1'b1;
      f.ex_load_dst = pdsf_pkg::REG_NONE;
      for (int i = 0; i < pdsf_pkg::FWD_COUNT; i++) begin
         f.fwd_dst[i] = pdsf_pkg::REG_NONE;
         f.fwd_val[i] = $urandom;
      end
      return f;
   endfunction

   // Register index biased to the implemented file, with some none and high ones
   function automatic logic [3:0] pick_reg();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 4'($urandom_range(0, RF_DEPTH - 1));
      if (roll < 85) return pdsf_pkg::REG_NONE;
      return 4'($urandom);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed steps with heavy forwarding and hazard traffic
   function automatic fetch_item_type random_fetch();
      fetch_item_type f;
      int roll;
      f = base_step(4'($urandom_range(pdsf_pkg::CODE_RRMOV, pdsf_pkg::CODE_POP)),
                    4'($urandom), pick_reg(), pick_reg());
      roll = $urandom_range(0, 99);
      if (program_ended && roll < 20) f.action = pdsf_pkg::ACT_RESTART;
      else if (roll == 0) f.action = pdsf_pkg::ACT_END;
      else if (roll == 1) f.action = pdsf_pkg::ACT_RESTART;
      else if (roll == 2) f.action = ACT_IGNORED;
      if ($urandom_range(0, 9) == 0) f.stat = 2'($urandom);
      if ($urandom_range(0, 6) == 0) f.code = 4'($urandom);
      f.const_word = pick_value();
      f.next_pc    = pick_value();
      roll = $urandom_range(0, 99);
      if (roll < 30)
         f.ex_code = $urandom_range(0, 1) ? pdsf_pkg::CODE_MRMOV : pdsf_pkg::CODE_POP;
      else if (roll < 50) f.ex_code = pdsf_pkg::CODE_JXX;
      else if (roll < 65) f.ex_code = CODE_NONE;
      else                f.ex_code = 4'($urandom);
      f.ex_cond     = ($urandom_range(0, 3) != 0);
      f.ex_load_dst = pick_reg();
      for (int i = 0; i < pdsf_pkg::FWD_COUNT; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)      f.fwd_dst[i] = pdsf_pkg::REG_NONE;
         else if (roll < 90) f.fwd_dst[i] = 4'($urandom_range(0, RF_DEPTH - 1));
         else                f.fwd_dst[i] = 4'($urandom);
         f.fwd_val[i] = pick_value();
      end
      return f;
   endfunction

   // Offer one word in bursts with random gaps, record its decode on accept
   task automatic send_fetch(input fetch_item_type f);
      logic [pdsf_pkg::REQ_TDATA_W-1:0] d;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      d = '0;
      d[pdsf_pkg::IN_WORD_LSB +: 10]  = {f.stat, f.code, f.ifun};
      d[pdsf_pkg::IN_REGS_LSB +: 8]   = {f.reg_a, f.reg_b};
      d[pdsf_pkg::IN_CONST_LSB +: 32] = f.const_word;
      d[pdsf_pkg::IN_NPC_LSB +: 32]   = f.next_pc;
      d[pdsf_pkg::IN_EXEC_LSB +: 9]   = {f.ex_code, f.ex_cond, f.ex_load_dst};
      for (int i = 0; i < pdsf_pkg::FWD_COUNT; i++) begin
         d[pdsf_pkg::IN_DESTS_LSB + 16 - 4 * i +: 4] = f.fwd_dst[i];
         d[pdsf_pkg::IN_VAL_LSB + pdsf_pkg::VAL_W * i +: pdsf_pkg::VAL_W] = f.fwd_val[i];
      end
      req_tdata  <= d;
      req_tuser  <= f.action;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_decodes.push_back(predict_decode(f));
      items_sent++;
   endtask

   // Stop offering and wait until every decoded word has come back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_decodes.size() != 0) @(posedge clock);
   endtask

   // Every instruction code with constant and next PC extremes
   task automatic test_decode_codes();
      fetch_item_type f;
      for (int c = CODE_HALT; c <= CODE_NONE; c++) begin
         if (c > pdsf_pkg::CODE_POP && c != CODE_NONE) continue;
         f = base_step(4'(c), 4'($urandom), 4'($urandom_range(0, RF_DEPTH - 1)),
                       4'($urandom_range(0, RF_DEPTH - 1)));
         f.const_word = c[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         f.next_pc    = c[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
         f.fwd_dst[4] = 4'(c % RF_DEPTH);
         send_fetch(f);
      end
      wait_drain();
   endtask

   // Forwarding priority, equal writeback indexes and unimplemented registers
   task automatic test_operand_forwarding();
      fetch_item_type f;
      f = base_step(pdsf_pkg::CODE_OPQ, 4'($urandom), 4'd3, 4'd3);
      for (int i = 0; i < pdsf_pkg::FWD_COUNT; i++) f.fwd_dst[i] = 4'd3;
      send_fetch(f);
      // both writeback ports hit r6: the loaded value must stick
      f = base_step(pdsf_pkg::CODE_RRMOV, 4'($urandom), 4'd6, 4'd1);
      f.fwd_dst[3] = 4'd6;
      f.fwd_dst[4] = 4'd6;
      send_fetch(f);
      f = base_step(pdsf_pkg::CODE_RMMOV, 4'($urandom), 4'd6, 4'd9);
      f.fwd_dst[4] = 4'd9;
      send_fetch(f);
      wait_drain();
   endtask

   // Mispredict, load-use replay and their interactions
   task automatic test_pipeline_hazards();
      fetch_item_type f;
      f = base_step(pdsf_pkg::CODE_OPQ, 4'($urandom), 4'd2, 4'd5);
      f.ex_code = pdsf_pkg::CODE_JXX;
      f.ex_cond = 1'b0;
      send_fetch(f);
      f = base_step(pdsf_pkg::CODE_OPQ, 4'($urandom), 4'd2, 4'd5);
      f.ex_code     = pdsf_pkg::CODE_MRMOV;
      f.ex_load_dst = 4'd5;
      send_fetch(f);
      // replayed word ignores the fetched code
      send_fetch(base_step(pdsf_pkg::CODE_IRMOV, 4'($urandom), 4'd2, 4'd5));
      f = base_step(pdsf_pkg::CODE_PUSH, 4'($urandom), 4'd1, 4'd0);
      f.ex_code     = pdsf_pkg::CODE_POP;
      f.ex_load_dst = pdsf_pkg::REG_SP;
      send_fetch(f);
      // mispredict while a replay is pending keeps the replay
      f = base_step(pdsf_pkg::CODE_RET, 4'($urandom), 4'd0, 4'd0);
      f.ex_code = pdsf_pkg::CODE_JXX;
      f.ex_cond = 1'b0;
      send_fetch(f);
      // a faulting fetch still consumes the replay
      f = base_step(pdsf_pkg::CODE_RET, 4'($urandom), 4'd0, 4'd0);
      f.stat = 2'd3;
      send_fetch(f);
      send_fetch(base_step(pdsf_pkg::CODE_CALL, 4'($urandom), 4'd7, 4'd7));
      wait_drain();
   endtask

   // End of program, steps after it, ignored action and restart
   task automatic test_end_and_restart();
      fetch_item_type f;
      f = base_step(pdsf_pkg::CODE_OPQ, 4'($urandom), 4'd1, 4'd2);
      f.action = pdsf_pkg::ACT_END;
      send_fetch(f);
      // writeback after end must not reach the file
      f.action     = pdsf_pkg::ACT_STEP;
      f.fwd_dst[3] = 4'd1;
      f.fwd_dst[4] = 4'd2;
      send_fetch(f);
      f.action = ACT_IGNORED;
      send_fetch(f);
      f.action = pdsf_pkg::ACT_RESTART;
      send_fetch(f);
      send_fetch(base_step(pdsf_pkg::CODE_OPQ, 4'($urandom), 4'd1, 4'd2));
      wait_drain();
   endtask

   task automatic test_random_stream(input int count);
      repeat (count) send_fetch(random_fetch());
      wait_drain();
   endtask

   // Receiver holds off long enough for the stage to fill and stall its input
   task automatic test_output_backpressure(input int count);
      hold_asks++;
      repeat (count) send_fetch(random_fetch());
      wait_drain();
   endtask

   // Receiver stall pattern, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen  <= hold_asks;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(16, 96);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (pattern_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Compare each returned word with the oldest expected decode
   always @(posedge clock) begin : check_rsp
      decoded_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.valid       = rsp_tuser[0];
         got.load_bubble = rsp_tuser[1];
         got.stat        = rsp_tdata[1:0];
         got.code        = rsp_tdata[9:2];
         got.sources     = rsp_tdata[17:10];
         got.dests       = rsp_tdata[25:18];
         got.val_a       = rsp_tdata[57:26];
         got.val_b       = rsp_tdata[89:58];
         got.val_c       = rsp_tdata[121:90];
         if (expected_decodes.size() == 0) begin
            $display("%0t unexpected word: expected none, got %h %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = expected_decodes.pop_front();
            compare_field("out_valid", 32'(want.valid), 32'(got.valid));
            compare_field("out_stat", 32'(want.stat), 32'(got.stat));
            compare_field("out_code", 32'(want.code), 32'(got.code));
            compare_field("out_sources", 32'(want.sources), 32'(got.sources));
            compare_field("out_dests", 32'(want.dests), 32'(got.dests));
            compare_field("out_val_a", want.val_a, got.val_a);
            compare_field("out_val_b", want.val_b, got.val_b);
            compare_field("out_val_c", want.val_c, got.val_c);
            compare_field("out_load_bubble", 32'(want.load_bubble),
                          32'(got.load_bubble));
            results_checked++;
            if (want.load_bubble) load_bubbles++;
            if (want.stat != pdsf_pkg::STAT_OK) stat_faults++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_decode_codes();
      test_operand_forwarding();
      test_pipeline_hazards();
      test_end_and_restart();
      test_random_stream(1790);
      test_output_backpressure(60);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Decoded %0d words from %0d requests: %0d load-use bubbles, %0d fetch faults,",
               results_checked, items_sent, load_bubbles, stat_faults);
      $display("with forwarding, replay, end/restart and output hold-off covered.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
